### hdl/tree_ancestor_query_engine_unit_assert.svh
// Assertion macros for the checker file taqe_chk.sv.
`ifndef TREE_ANCESTOR_QUERY_ENGINE_UNIT_ASSERT_SVH
`define TREE_ANCESTOR_QUERY_ENGINE_UNIT_ASSERT_SVH
// Checks that the consequent holds in the same cycle as the antecedent.
`define TAQE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tree ancestor query engine check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define TAQE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tree ancestor query engine check failed");
`endif

### hdl/taqe_pkg.sv
package taqe_pkg;
  localparam int NODE_W = 10;
  localparam int NODES = 1 << NODE_W;
  localparam int LEVELS = 10;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int DEPTH_W = 10;
  localparam int INFO_W = DEPTH_W + 1;
  localparam int ENTRY_W = NODE_W + 1;
  localparam int DIST_W = DEPTH_W + 1;
  localparam int OP_W = 2;
  localparam int JDEPTH = NODES * LEVELS;
  localparam int JADDR_W = $clog2(JDEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ROOT  = 2'd0,
    OP_CHILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ANSWER = 2'd0,
    ST_STORED = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INFO_A, S_INFO_B, S_ROOT_FILL, S_CH_RD, S_CH_WR,
    S_LIFT, S_LIFT_W, S_EQ, S_UP, S_UP_W, S_PAR, S_PAR_W, S_LCA_RD
  } state_t;

  function automatic logic [JADDR_W-1:0] jaddr(input logic [NODE_W-1:0] node,
                                               input logic [LVL_W-1:0] lvl);
    jaddr = JADDR_W'(node) * JADDR_W'(LEVELS) + JADDR_W'(lvl);
  endfunction
endpackage

### hdl/tree_ancestor_query_engine_unit.sv
// Each item, whether rejected, a root store, a child store or a query, runs from the
// start transfer to the done strobe; child stores and queries walk the jump table.
// One item is in work at a time, so a new item is taken only once the last is done.
// Results are shown for one cycle on done; the receiver cannot stall.
// After reset busy stays high while the node store is cleared.
module tree_ancestor_query_engine_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [taqe_pkg::OP_W-1:0]    op,
  input  logic [taqe_pkg::NODE_W-1:0]  first_node,
  input  logic [taqe_pkg::NODE_W-1:0]  second_node,
  output logic                         busy,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [taqe_pkg::NODE_W-1:0]  ancestor,
  output logic [taqe_pkg::DIST_W-1:0]  distance
);
  import taqe_pkg::*;

  logic [INFO_W-1:0]  info_mem [NODES];
  logic [ENTRY_W-1:0] jump_mem [JDEPTH];

  state_t state, state_next;
  op_t op_r, op_r_next;
  logic [NODE_W-1:0] node_a, node_a_next, node_b, node_b_next;
  logic [NODE_W-1:0] v, v_next, u, u_next, lca, lca_next;
  logic [DEPTH_W-1:0] da, da_next, db, db_next, dh, dh_next;
  logic va, va_next;
  logic [LVL_W-1:0] k, k_next;
  logic [ENTRY_W-1:0] cur, cur_next;
  logic [NODE_W-1:0] clr_cnt, clr_cnt_next;

  logic info_we;
  logic [NODE_W-1:0] info_raddr, info_waddr;
  logic [INFO_W-1:0] info_wdata, info_q;
  logic jump_we;
  logic [JADDR_W-1:0] jump_waddr, jump_raddr0, jump_raddr1;
  logic [ENTRY_W-1:0] jump_wdata, jump_q0, jump_q1;

  logic fin;
  status_t fin_status;
  logic [NODE_W-1:0] fin_anc;
  logic [DIST_W-1:0] fin_dist;

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_waddr] <= info_wdata;
    end
    info_q <= info_mem[info_raddr];
  end

  always_ff @(posedge clk) begin
    if (jump_we) begin
      jump_mem[jump_waddr] <= jump_wdata;
    end
    jump_q0 <= jump_mem[jump_raddr0];
    jump_q1 <= jump_mem[jump_raddr1];
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_r_next = op_r;
    node_a_next = node_a;
    node_b_next = node_b;
    v_next = v;
    u_next = u;
    lca_next = lca;
    da_next = da;
    db_next = db;
    dh_next = dh;
    va_next = va;
    k_next = k;
    cur_next = cur;
    clr_cnt_next = clr_cnt;
    info_we = 1'b0;
    info_raddr = node_a;
    info_waddr = node_a;
    info_wdata = '0;
    jump_we = 1'b0;
    jump_waddr = jaddr(node_a, k + LVL_W'(1));
    jump_wdata = '0;
    jump_raddr0 = jaddr(v, k);
    jump_raddr1 = jaddr(u, k);
    fin = 1'b0;
    fin_status = ST_ERROR;
    fin_anc = '0;
    fin_dist = '0;
    case (state)
      S_CLEAR: begin
        info_we = 1'b1;
        info_waddr = clr_cnt;
        clr_cnt_next = clr_cnt + NODE_W'(1);
        if (clr_cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        info_raddr = first_node;
        if (start) begin
          op_r_next = op_t'(op);
          node_a_next = first_node;
          node_b_next = second_node;
          state_next = S_INFO_A;
        end
      end
      S_INFO_A: begin
        va_next = info_q[DEPTH_W];
        da_next = info_q[DEPTH_W-1:0];
        info_raddr = node_b;
        state_next = S_INFO_B;
      end
      S_INFO_B: begin
        state_next = S_IDLE;
        db_next = info_q[DEPTH_W-1:0];
        case (op_r)
          OP_ROOT: begin
            if (!va) begin
              info_we = 1'b1;
              info_wdata = {1'b1, {DEPTH_W{1'b0}}};
              k_next = '0;
              state_next = S_ROOT_FILL;
            end else begin
              fin = 1'b1;
            end
          end
          OP_CHILD: begin
            if (!va && info_q[DEPTH_W] && (info_q[DEPTH_W-1:0] != '1)) begin
              info_we = 1'b1;
              info_wdata = {1'b1, info_q[DEPTH_W-1:0] + DEPTH_W'(1)};
              jump_we = 1'b1;
              jump_waddr = jaddr(node_a, '0);
              jump_wdata = {1'b1, node_b};
              cur_next = {1'b1, node_b};
              k_next = '0;
              state_next = S_CH_RD;
            end else begin
              fin = 1'b1;
            end
          end
          OP_QUERY: begin
            if (va && info_q[DEPTH_W]) begin
              if (info_q[DEPTH_W-1:0] > da) begin
                v_next = node_a;
                u_next = node_b;
                dh_next = info_q[DEPTH_W-1:0] - da;
              end else begin
                v_next = node_b;
                u_next = node_a;
                dh_next = da - info_q[DEPTH_W-1:0];
              end
              k_next = LVL_W'(LEVELS - 1);
              state_next = S_LIFT;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_ROOT_FILL: begin
        jump_we = 1'b1;
        jump_waddr = jaddr(node_a, k);
        k_next = k + LVL_W'(1);
        if (k == LVL_W'(LEVELS - 1)) begin
          fin = 1'b1;
          fin_status = ST_STORED;
          state_next = S_IDLE;
        end
      end
      S_CH_RD: begin
        if (cur[NODE_W]) begin
          jump_raddr0 = jaddr(cur[NODE_W-1:0], k);
          state_next = S_CH_WR;
        end else begin
          jump_we = 1'b1;
          k_next = k + LVL_W'(1);
          if (k == LVL_W'(LEVELS - 2)) begin
            fin = 1'b1;
            fin_status = ST_STORED;
            state_next = S_IDLE;
          end
        end
      end
      S_CH_WR: begin
        jump_we = 1'b1;
        jump_wdata = jump_q0;
        cur_next = jump_q0;
        k_next = k + LVL_W'(1);
        if (k == LVL_W'(LEVELS - 2)) begin
          fin = 1'b1;
          fin_status = ST_STORED;
          state_next = S_IDLE;
        end else begin
          state_next = S_CH_RD;
        end
      end
      S_LIFT: begin
        if (dh[k]) begin
          jump_raddr0 = jaddr(u, k);
          state_next = S_LIFT_W;
        end else if (k == '0) begin
          state_next = S_EQ;
        end else begin
          k_next = k - LVL_W'(1);
        end
      end
      S_LIFT_W: begin
        if (jump_q0[NODE_W]) begin
          u_next = jump_q0[NODE_W-1:0];
        end
        if (k == '0) begin
          state_next = S_EQ;
        end else begin
          k_next = k - LVL_W'(1);
          state_next = S_LIFT;
        end
      end
      S_EQ: begin
        if (u == v) begin
          lca_next = v;
          info_raddr = v;
          state_next = S_LCA_RD;
        end else begin
          k_next = LVL_W'(LEVELS - 1);
          state_next = S_UP;
        end
      end
      S_UP: begin
        state_next = S_UP_W;
      end
      S_UP_W: begin
        if ((jump_q0 != jump_q1) && jump_q0[NODE_W] && jump_q1[NODE_W]) begin
          v_next = jump_q0[NODE_W-1:0];
          u_next = jump_q1[NODE_W-1:0];
        end
        if (k == '0) begin
          state_next = S_PAR;
        end else begin
          k_next = k - LVL_W'(1);
          state_next = S_UP;
        end
      end
      S_PAR: begin
        state_next = S_PAR_W;
      end
      S_PAR_W: begin
        if (jump_q0[NODE_W] && (jump_q0 == jump_q1)) begin
          lca_next = jump_q0[NODE_W-1:0];
          info_raddr = jump_q0[NODE_W-1:0];
          state_next = S_LCA_RD;
        end else begin
          fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LCA_RD: begin
        fin = 1'b1;
        fin_status = ST_ANSWER;
        fin_anc = lca;
        fin_dist = {1'b0, da} + {1'b0, db} - {info_q[DEPTH_W-1:0], 1'b0};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      done <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_r_next;
    node_a <= node_a_next;
    node_b <= node_b_next;
    v <= v_next;
    u <= u_next;
    lca <= lca_next;
    da <= da_next;
    db <= db_next;
    dh <= dh_next;
    va <= va_next;
    k <= k_next;
    cur <= cur_next;
    if (fin) begin
      status <= fin_status;
      ancestor <= fin_anc;
      distance <= fin_dist;
    end
  end
endmodule

### hdl/taqe_chk.sv
`include "tree_ancestor_query_engine_unit_assert.svh"
module taqe_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic [taqe_pkg::OP_W-1:0]    op,
  input logic [taqe_pkg::NODE_W-1:0]  first_node,
  input logic [taqe_pkg::NODE_W-1:0]  second_node,
  input logic                         busy,
  input logic                         done,
  input logic [1:0]                   status,
  input logic [taqe_pkg::NODE_W-1:0]  ancestor,
  input logic [taqe_pkg::DIST_W-1:0]  distance
);
  import taqe_pkg::*;

  `TAQE_ASSERT_SAME(a_status_code, done, (status == ST_ANSWER) || (status == ST_STORED) || (status == ST_ERROR))
  `TAQE_ASSERT_SAME(a_zero_unless_answer, done && (status != ST_ANSWER), (ancestor == '0) && (distance == '0))
  `TAQE_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy)
  `TAQE_ASSERT_NEXT(a_single_strobe, done, !done)
endmodule

bind tree_ancestor_query_engine_unit taqe_chk u_taqe_chk (.*);

### test/tree_ancestor_query_engine_unit_tb.sv
`timescale 1ns / 1ps
module tree_ancestor_query_engine_unit_tb;
  import taqe_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OP_W-1:0] op = '0;
  logic [NODE_W-1:0] first_node = '0;
  logic [NODE_W-1:0] second_node = '0;
  logic busy, done;
  logic [1:0] status;
  logic [NODE_W-1:0] ancestor;
  logic [DIST_W-1:0] distance;

  tree_ancestor_query_engine_unit DUT (
    .clk(clk), .rst(rst), .start(start), .op(op), .first_node(first_node),
    .second_node(second_node), .busy(busy), .done(done), .status(status),
    .ancestor(ancestor), .distance(distance)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic [1:0] st;
    logic [NODE_W-1:0] anc;
    logic [DIST_W-1:0] span;
  } lca_answer_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit fixed;
    lca_answer_t ans;
  } row_t;

  bit tree_valid [NODES];
  logic [DEPTH_W-1:0] tree_depth [NODES];
  logic [ENTRY_W-1:0] tree_jump [NODES][LEVELS];
  lca_answer_t pending_answers[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  logic [NODE_W-1:0] stored_list[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [NODE_W-1:0] climb(input logic [NODE_W-1:0] n,
                                              input int dh);
    for (int k = LEVELS - 1; k >= 0; k--)
      if (dh[k] && tree_jump[n][k][NODE_W]) n = tree_jump[n][k][NODE_W-1:0];
    return n;
  endfunction

  function automatic lca_answer_t predict_lca(input logic [OP_W-1:0] o,
                                              input logic [NODE_W-1:0] a,
                                              input logic [NODE_W-1:0] b);
    lca_answer_t r;
    logic [NODE_W-1:0] v, u, t, l;
    logic [ENTRY_W-1:0] pv, pu, w;
    bit found;
    int d;
    r.st = ST_ERROR; r.anc = '0; r.span = '0;
    found = 1'b0; l = '0;
    if (o == OP_ROOT) begin
      if (!tree_valid[a]) begin
        tree_valid[a] = 1'b1;
        tree_depth[a] = '0;
        for (int k = 0; k < LEVELS; k++) tree_jump[a][k] = '0;
        stored_list.insert(stored_list.size(), a);
        r.st = ST_STORED;
      end
    end else if (o == OP_CHILD) begin
      if (!tree_valid[a] && tree_valid[b]) begin
        d = int'(tree_depth[b]) + 1;
        if (d <= 1023) begin
          tree_valid[a] = 1'b1;
          tree_depth[a] = DEPTH_W'(d);
          tree_jump[a][0] = {1'b1, b};
          for (int k = 0; k + 1 < LEVELS; k++) begin
            w = tree_jump[a][k];
            tree_jump[a][k+1] = w[NODE_W] ? tree_jump[w[NODE_W-1:0]][k] : '0;
          end
          stored_list.insert(stored_list.size(), a);
          r.st = ST_STORED;
        end
      end
    end else if (o == OP_QUERY) begin
      if (tree_valid[a] && tree_valid[b]) begin
        v = a; u = b;
        if (tree_depth[v] > tree_depth[u]) begin
          t = v; v = u; u = t;
        end
        u = climb(u, int'(tree_depth[u]) - int'(tree_depth[v]));
        if (u == v) begin
          l = v; found = 1'b1;
        end else begin
          for (int k = LEVELS - 1; k >= 0; k--) begin
            pv = tree_jump[v][k]; pu = tree_jump[u][k];
            if (pv != pu && pv[NODE_W] && pu[NODE_W]) begin
              v = pv[NODE_W-1:0]; u = pu[NODE_W-1:0];
            end
          end
          pv = tree_jump[v][0]; pu = tree_jump[u][0];
          if (pv[NODE_W] && pv == pu) begin
            l = pv[NODE_W-1:0]; found = 1'b1;
          end
        end
        if (found) begin
          r.st = ST_ANSWER; r.anc = l;
          r.span = DIST_W'(int'(tree_depth[a]) + int'(tree_depth[b]) - 2 * int'(tree_depth[l]));
        end
      end
    end
    return r;
  endfunction

  task automatic issue(input logic [OP_W-1:0] o, input logic [NODE_W-1:0] a,
                       input logic [NODE_W-1:0] b, input bit fixed,
                       input lca_answer_t want);
    lca_answer_t p;
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(19, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; op <= o; first_node <= a; second_node <= b;
    do @(posedge clk); while (busy);
    p = predict_lca(o, a, b);
    if (fixed && (p.st != want.st || p.anc != want.anc || p.span != want.span))
      report_mismatch("directed table entry", 32'(p.st), 32'(want.st));
    pending_answers.insert(pending_answers.size(), p);
  endtask

  always @(posedge clk) begin
    lca_answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 0);
      end else begin
        e = pending_answers.pop_front();
        if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
        if (ancestor !== e.anc) report_mismatch("ancestor", 32'(ancestor), 32'(e.anc));
        if (distance !== e.span) report_mismatch("distance", 32'(distance), 32'(e.span));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic lca_answer_t mk(input logic [1:0] s, input int an, input int di);
    lca_answer_t r;
    r.st = s; r.anc = NODE_W'(an); r.span = DIST_W'(di);
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] pick_stored();
    if (stored_list.size() == 0) return NODE_W'($urandom);
    return stored_list[$urandom_range(stored_list.size() - 1)];
  endfunction

  row_t table_rows[$];
  lca_answer_t none;

  initial begin
    int r, n;
    logic [OP_W-1:0] o;
    logic [NODE_W-1:0] a, b, chain;
    none = mk(ST_ERROR, 0, 0);
    for (int i = 0; i < NODES; i++) tree_valid[i] = 1'b0;
    table_rows = '{
      '{OP_QUERY, 10'd0, 10'd0, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_CHILD, 10'd5, 10'd0, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_NONE, 10'd1023, 10'd1023, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_ROOT, 10'd0, 10'd1023, 1'b1, mk(ST_STORED, 0, 0)},
      '{OP_ROOT, 10'd0, 10'd0, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_ROOT, 10'd1023, 10'd0, 1'b1, mk(ST_STORED, 0, 0)},
      '{OP_CHILD, 10'd1, 10'd0, 1'b1, mk(ST_STORED, 0, 0)},
      '{OP_CHILD, 10'd2, 10'd0, 1'b1, mk(ST_STORED, 0, 0)},
      '{OP_CHILD, 10'd3, 10'd1, 1'b0, none},
      '{OP_CHILD, 10'd4, 10'd3, 1'b0, none},
      '{OP_CHILD, 10'd1, 10'd2, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_QUERY, 10'd0, 10'd0, 1'b1, mk(ST_ANSWER, 0, 0)},
      '{OP_QUERY, 10'd1, 10'd2, 1'b1, mk(ST_ANSWER, 0, 2)},
      '{OP_QUERY, 10'd4, 10'd2, 1'b0, none},
      '{OP_QUERY, 10'd4, 10'd1, 1'b0, none},
      '{OP_QUERY, 10'd0, 10'd4, 1'b0, none},
      '{OP_QUERY, 10'd0, 10'd1023, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_QUERY, 10'd4, 10'd1000, 1'b1, mk(ST_ERROR, 0, 0)},
      '{OP_CHILD, 10'd1022, 10'd1023, 1'b0, none},
      '{OP_QUERY, 10'd1022, 10'd1023, 1'b0, none}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i])
      issue(table_rows[i].op, table_rows[i].a, table_rows[i].b,
            table_rows[i].fixed, table_rows[i].ans);
    // A deep chain, to exercise every lifting level.
    chain = 10'd1022;
    n = 0;
    for (int i = 0; i < NODES && n < 600; i++) begin
      if (!tree_valid[i]) begin
        issue(OP_CHILD, NODE_W'(i), chain, 1'b0, none);
        if (tree_valid[i]) chain = NODE_W'(i);
        n++;
      end
    end
    for (int i = 0; i < 100; i++) issue(OP_QUERY, pick_stored(), pick_stored(), 1'b0, none);
    // Clear the tree is impossible without reset, so build more roots as
    // nodes remain and query heavily.
    for (int i = 0; i < 580; i++) begin
      if (i > 480) quiet = 1'b1;
      r = $urandom_range(99);
      a = NODE_W'($urandom); b = NODE_W'($urandom);
      if (r < 6) o = OP_ROOT;
      else if (r < 30) begin o = OP_CHILD; b = pick_stored(); end
      else if (r < 36) o = OP_CHILD;
      else if (r < 90) begin o = OP_QUERY; a = pick_stored(); b = pick_stored(); end
      else if (r < 96) o = OP_QUERY;
      else o = OP_NONE;
      issue(o, a, b, 1'b0, none);
    end
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
